@@ hdl/lst_pkg.sv @@
// Shared types and constants for the link sequence tracker.
package lst_pkg;

	// Event codes carried in the mode field.
	typedef enum logic [2:0] {
		MODE_ACCEPT_HELLO = 3'd0,
		MODE_REJECT       = 3'd1,
		MODE_TIMEOUT      = 3'd2,
		MODE_OBSERVE      = 3'd3,
		MODE_SET_CONTROL  = 3'd4,
		MODE_CLR_CONTROL  = 3'd5,
		MODE_STOP         = 3'd6,
		MODE_QUERY        = 3'd7
	} mode_t;

	// Link state codes.
	localparam logic [1:0] LINK_WAIT_HELLO = 2'd0;
	localparam logic [1:0] LINK_READY      = 2'd1;
	localparam logic [1:0] LINK_LOST       = 2'd2;

	// Observation outcome codes.
	localparam logic [1:0] DEC_NEW       = 2'd0;
	localparam logic [1:0] DEC_DUPLICATE = 2'd1;
	localparam logic [1:0] DEC_OLD       = 2'd2;

	localparam int SEQ_W = 32;
	localparam int GAP_W = 31;

	// Half of the sequence number space.
	localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h8000_0000;

	// One input beat.
	typedef struct packed {
		logic [2:0]       mode;
		logic [SEQ_W-1:0] sequence_number;
		logic [SEQ_W-1:0] peer_id;
		logic             stop_flag;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]       decision;
		logic [GAP_W-1:0] gap;
		logic             peer_ready;
		logic [1:0]       link_status;
		logic             control_ok;
		logic             stop_latched;
		logic [SEQ_W-1:0] last_rx_sequence;
		logic [SEQ_W-1:0] last_control_sequence;
		logic [SEQ_W-1:0] total_gaps;
	} rsp_t;

endpackage

@@ hdl/lst_req_if.sv @@
// Input channel of the link sequence tracker: one event per beat.
interface lst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] sequence_number;
	logic [31:0] peer_id;
	logic        stop_flag;

	modport source (output valid, mode, sequence_number, peer_id, stop_flag, input ready);
	modport sink (input valid, mode, sequence_number, peer_id, stop_flag, output ready);
endinterface

@@ hdl/lst_rsp_if.sv @@
// Result channel of the link sequence tracker: one status report per beat.
interface lst_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  decision;
	logic [30:0] gap;
	logic        peer_ready;
	logic [1:0]  link_status;
	logic        control_ok;
	logic        stop_latched;
	logic [31:0] last_rx_sequence;
	logic [31:0] last_control_sequence;
	logic [31:0] total_gaps;

	modport source (output valid, decision, gap, peer_ready, link_status, control_ok,
		stop_latched, last_rx_sequence, last_control_sequence, total_gaps, input ready);
	modport sink (input valid, decision, gap, peer_ready, link_status, control_ok,
		stop_latched, last_rx_sequence, last_control_sequence, total_gaps, output ready);
endinterface

@@ hdl/lst_core.sv @@
// Tracker state and the per-event update that produces one result.
module lst_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  lst_pkg::req_t item,
	output lst_pkg::rsp_t result
);
	import lst_pkg::*;

	logic [1:0]       link_mode_q, link_mode_d;
	logic             stop_q, stop_d;
	logic             control_q, control_d;
	logic             peer_known_q, peer_known_d;
	logic             base_known_q, base_known_d;
	logic [SEQ_W-1:0] peer_id_q, peer_id_d;
	logic [SEQ_W-1:0] rx_seq_q, rx_seq_d;
	logic [SEQ_W-1:0] control_seq_q, control_seq_d;
	logic [SEQ_W-1:0] gap_sum_q, gap_sum_d;

	logic [SEQ_W-1:0] diff;
	logic [SEQ_W-1:0] diff_m1;
	logic [1:0]       decision;
	logic [GAP_W-1:0] gap;
	logic             peer_ready;

	// Forward distance from the last accepted number and the gap it implies.
	assign diff    = item.sequence_number - rx_seq_q;
	assign diff_m1 = diff - SEQ_W'(1);

	// Next state and event outcome.
	always_comb begin
		link_mode_d   = link_mode_q;
		stop_d        = stop_q;
		control_d     = control_q;
		peer_known_d  = peer_known_q;
		base_known_d  = base_known_q;
		peer_id_d     = peer_id_q;
		rx_seq_d      = rx_seq_q;
		control_seq_d = control_seq_q;
		gap_sum_d     = gap_sum_q;
		decision      = DEC_NEW;
		gap           = '0;
		peer_ready    = 1'b0;
		case (mode_t'(item.mode))
			MODE_ACCEPT_HELLO: begin
				peer_known_d = 1'b1;
				peer_id_d    = item.peer_id;
				base_known_d = 1'b1;
				rx_seq_d     = item.sequence_number;
				control_d    = 1'b0;
				link_mode_d  = LINK_READY;
			end
			MODE_REJECT: begin
				link_mode_d  = LINK_WAIT_HELLO;
				peer_known_d = 1'b0;
				base_known_d = 1'b0;
				control_d    = 1'b0;
			end
			MODE_TIMEOUT: begin
				link_mode_d  = LINK_LOST;
				peer_known_d = 1'b0;
				base_known_d = 1'b0;
				control_d    = 1'b0;
			end
			MODE_OBSERVE: begin
				if (!base_known_q) begin
					base_known_d = 1'b1;
					rx_seq_d     = item.sequence_number;
				end else if (diff == '0) begin
					decision = DEC_DUPLICATE;
				end else if (diff < HALF_RANGE) begin
					gap       = diff_m1[GAP_W-1:0];
					gap_sum_d = gap_sum_q + {1'b0, diff_m1[GAP_W-1:0]};
					rx_seq_d  = item.sequence_number;
				end else begin
					decision = DEC_OLD;
				end
			end
			MODE_SET_CONTROL: begin
				control_d     = 1'b1;
				control_seq_d = item.sequence_number;
			end
			MODE_CLR_CONTROL: begin
				control_d = 1'b0;
			end
			MODE_STOP: begin
				stop_d = item.stop_flag;
				if (item.stop_flag) begin
					control_d = 1'b0;
				end
			end
			MODE_QUERY: begin
				peer_ready = (link_mode_q == LINK_READY) && peer_known_q &&
					(peer_id_q == item.peer_id);
			end
			default: begin
				peer_ready = 1'b0;
			end
		endcase
	end

	// Result reports the outcome and the state after the event.
	always_comb begin
		result.decision              = decision;
		result.gap                   = gap;
		result.peer_ready            = peer_ready;
		result.link_status           = link_mode_d;
		result.control_ok            = control_d;
		result.stop_latched          = stop_d;
		result.last_rx_sequence      = rx_seq_d;
		result.last_control_sequence = control_seq_d;
		result.total_gaps            = gap_sum_d;
	end

	// State registers, updated once per event taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q   <= LINK_WAIT_HELLO;
			stop_q        <= 1'b0;
			control_q     <= 1'b0;
			peer_known_q  <= 1'b0;
			base_known_q  <= 1'b0;
			peer_id_q     <= '0;
			rx_seq_q      <= '0;
			control_seq_q <= '0;
			gap_sum_q     <= '0;
		end else if (take) begin
			link_mode_q   <= link_mode_d;
			stop_q        <= stop_d;
			control_q     <= control_d;
			peer_known_q  <= peer_known_d;
			base_known_q  <= base_known_d;
			peer_id_q     <= peer_id_d;
			rx_seq_q      <= rx_seq_d;
			control_seq_q <= control_seq_d;
			gap_sum_q     <= gap_sum_d;
		end
	end

endmodule

@@ hdl/link_sequence_tracker_top.sv @@
// Top level of the link sequence tracker: input register, tracker core, result register.
//
// The req channel takes one event per beat (mode, sequence_number, peer_id,
// stop_flag); the rsp channel returns exactly one status beat per event, in
// order. Both use valid/ready and a beat moves when both are high.
// An accepted event is held in the input register, is applied to
// the tracker state by combinational logic (two 32-bit subtracts, compares and
// an add) and lands in the result register, from which it is offered on rsp.
// Throughput is one event per cycle for as long as rsp is ready.
// When rsp stalls, the result register holds its beat, the input register
// holds the next event and req.ready drops once both are full; no event is
// lost and the state advances only when its result can be stored.
// Asynchronous reset (arst_n low) empties both registers, puts the link into
// wait-for-hello and clears every flag, sequence and the gap total.
module link_sequence_tracker_top (
	input  logic clk,
	input  logic arst_n,
	lst_req_if.sink   req,
	lst_rsp_if.source rsp
);
	import lst_pkg::*;

	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	rsp_t result_s2;
	rsp_t result;
	logic advance;

	// The stage moves when the result register is empty or being drained.
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.mode            <= req.mode;
			item_s1.sequence_number <= req.sequence_number;
			item_s1.peer_id         <= req.peer_id;
			item_s1.stop_flag       <= req.stop_flag;
		end
	end

	lst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (valid_s1 && advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	// Drive the result channel.
	assign rsp.valid                 = valid_s2;
	assign rsp.decision              = result_s2.decision;
	assign rsp.gap                   = result_s2.gap;
	assign rsp.peer_ready            = result_s2.peer_ready;
	assign rsp.link_status           = result_s2.link_status;
	assign rsp.control_ok            = result_s2.control_ok;
	assign rsp.stop_latched          = result_s2.stop_latched;
	assign rsp.last_rx_sequence      = result_s2.last_rx_sequence;
	assign rsp.last_control_sequence = result_s2.last_control_sequence;
	assign rsp.total_gaps            = result_s2.total_gaps;

endmodule
